[hdl/hbs_pkg.sv]
// Shared types and constants for the heightmap bilinear sampler.
`default_nettype none
package hbs_pkg;

  localparam int MODE_W         = 1;
  localparam int GRID_INDEX_W   = 17;
  localparam int SAMPLE_W       = 16;
  localparam int WORLD_W        = 32;
  localparam int HEIGHT_W       = 32;
  localparam int GRID_DIM_W     = 9;
  localparam int INV_SCALE_W    = 24;
  localparam int HEIGHT_SCALE_W = 31;
  localparam int STORE_W        = 31;
  localparam int LOAD_SHIFT     = 16;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 31;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_DIM     = 2'd0,
    REG_INV_SCALE_X  = 2'd1,
    REG_INV_SCALE_Z  = 2'd2,
    REG_HEIGHT_SCALE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GRID_DIM_W-1:0]     grid_dim;
    logic [INV_SCALE_W-1:0]    inv_scale_x;
    logic [INV_SCALE_W-1:0]    inv_scale_z;
    logic [HEIGHT_SCALE_W-1:0] height_scale;
  } cfg_t;

endpackage
`default_nettype wire

[hdl/hbs_if.sv]
// Request and result channel interfaces of the heightmap sampler.
`default_nettype none
interface hbs_in_if import hbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [GRID_INDEX_W-1:0] grid_index;
  logic [SAMPLE_W-1:0]     sample_value;
  logic signed [WORLD_W-1:0] world_x;
  logic signed [WORLD_W-1:0] world_z;

  modport source (output valid, mode, grid_index, sample_value, world_x, world_z,
                  input ready);
  modport sink (input valid, mode, grid_index, sample_value, world_x, world_z,
                output ready);
endinterface

interface hbs_out_if import hbs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height;
  logic                       off_terrain;

  modport source (output valid, height, off_terrain, input ready);
  modport sink (input valid, height, off_terrain, output ready);
endinterface
`default_nettype wire

[hdl/heightmap_bilinear_sampler.sv]
// Heightmap bilinear sampler for loads and height queries.
// Throughput: one request per cycle unless output back-pressure stalls it;
// the four corner reads come from four replicated height stores, each with
// one read port. Loads give no result. Reset (synchronous, rst_n low) clears
// all control state and restores the registers; the height stores keep their
// contents.
`default_nettype none
module heightmap_bilinear_sampler import hbs_pkg::*; #(
  parameter int MAX_DIM = 257,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  hbs_in_if.sink                      in_chan,
  hbs_out_if.source                   out_chan
);

  localparam int IDX_W   = $clog2(MAX_DIM * MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int ENTRY_W = 2 + IDX_W + 2 * FRAC_BITS + STORE_W;

  cfg_t               cfg_r;
  logic [DIM_W-1:0]   dim;
  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_data, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_dim     <= GRID_DIM_W'(257);
      cfg_r.inv_scale_x  <= INV_SCALE_W'(65536);
      cfg_r.inv_scale_z  <= INV_SCALE_W'(65536);
      cfg_r.height_scale <= HEIGHT_SCALE_W'(65536);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_DIM:     cfg_r.grid_dim     <= cfg_data[GRID_DIM_W-1:0];
        REG_INV_SCALE_X:  cfg_r.inv_scale_x  <= cfg_data[INV_SCALE_W-1:0];
        REG_INV_SCALE_Z:  cfg_r.inv_scale_z  <= cfg_data[INV_SCALE_W-1:0];
        REG_HEIGHT_SCALE: cfg_r.height_scale <= cfg_data[HEIGHT_SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp grid size to 2..MAX_DIM
  always_comb begin
    if (int'(cfg_r.grid_dim) < 2) begin
      dim = DIM_W'(2);
    end else if (int'(cfg_r.grid_dim) > MAX_DIM) begin
      dim = DIM_W'(MAX_DIM);
    end else begin
      dim = DIM_W'(cfg_r.grid_dim);
    end
  end

  hbs_front #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .dim     (dim),
    .in_chan (in_chan),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_full  (q_full)
  );

  hbs_fifo #(.WIDTH(ENTRY_W), .DEPTH(4)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  hbs_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .dim      (dim),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

[hdl/hbs_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module hbs_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 66049,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/hbs_fifo.sv]
// Short request queue between the front and back parts.
`default_nettype none
module hbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/hbs_front.sv]
// Front part: accepts requests, scales coordinates, classifies and queues them.
`default_nettype none
module hbs_front import hbs_pkg::*; #(
  parameter int MAX_DIM = 257,
  parameter int FRAC_BITS = 16,
  localparam int IDX_W = $clog2(MAX_DIM * MAX_DIM),
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int ENTRY_W = 2 + IDX_W + 2 * FRAC_BITS + STORE_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic [DIM_W-1:0]   dim,
  hbs_in_if.sink                  in_chan,
  output logic                    q_push,
  output logic      [ENTRY_W-1:0] q_data,
  input  wire logic               q_full
);

  localparam int PX_W  = WORLD_W - 1 + INV_SCALE_W;
  localparam int GX_W  = PX_W - FRAC_BITS;
  localparam int X0_W  = GX_W - FRAC_BITS;
  localparam int CMP_W = ((X0_W > DIM_W) ? X0_W : DIM_W) + 1;
  localparam int LP_W  = SAMPLE_W + HEIGHT_SCALE_W;
  localparam int ROW_W = 2 * DIM_W;

  typedef struct packed {
    logic                 isq;
    logic                 off;
    logic [IDX_W-1:0]     base;
    logic [FRAC_BITS-1:0] tx;
    logic [FRAC_BITS-1:0] tz;
    logic [STORE_W-1:0]   wdata;
  } qent_t;

  logic adv1, adv2, adv3;

  // stage 1: captured request
  logic                    f1_v_r, f1_mode_r;
  logic [GRID_INDEX_W-1:0] f1_idx_r;
  logic [SAMPLE_W-1:0]     f1_smp_r;
  logic [WORLD_W-1:0]      f1_wx_r, f1_wz_r;
  // stage 2: products
  logic                    f2_v_r, f2_mode_r, f2_neg_r, f2_idx_ok_r;
  logic [GRID_INDEX_W-1:0] f2_idx_r;
  logic [PX_W-1:0]         f2_px_r, f2_pz_r;
  logic [LP_W-1:0]         f2_lp_r;
  // stage 3: classified
  logic                    f3_v_r, f3_mode_r, f3_off_r, f3_drop_r;
  logic [GRID_INDEX_W-1:0] f3_idx_r;
  logic [DIM_W-1:0]        f3_x0_r, f3_z0_r;
  logic [FRAC_BITS-1:0]    f3_tx_r, f3_tz_r;
  logic [STORE_W-1:0]      f3_wdata_r;

  logic [ROW_W-1:0] dim_sq_r;

  logic [GX_W-1:0]  gx, gz;
  logic [X0_W-1:0]  x0f, z0f;
  logic             x_off, z_off;
  logic [LP_W:0]    lp_rnd;
  logic [ROW_W-1:0] row;
  qent_t            ent;

  assign adv3 = !f3_v_r || f3_drop_r || !q_full;
  assign adv2 = !f2_v_r || adv3;
  assign adv1 = !f1_v_r || adv2;
  assign in_chan.ready = adv1;

  always_ff @(posedge clk) begin
    dim_sq_r <= ROW_W'(dim) * ROW_W'(dim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else begin
      if (adv1) f1_v_r <= in_chan.valid;
      if (adv2) f2_v_r <= f1_v_r;
      if (adv3) f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      f1_mode_r <= in_chan.mode;
      f1_idx_r  <= in_chan.grid_index;
      f1_smp_r  <= in_chan.sample_value;
      f1_wx_r   <= in_chan.world_x;
      f1_wz_r   <= in_chan.world_z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      f2_mode_r   <= f1_mode_r;
      f2_idx_r    <= f1_idx_r;
      f2_idx_ok_r <= (ROW_W + GRID_INDEX_W)'(f1_idx_r) < (ROW_W + GRID_INDEX_W)'(dim_sq_r);
      f2_neg_r    <= f1_wx_r[WORLD_W-1] | f1_wz_r[WORLD_W-1];
      f2_px_r     <= PX_W'(f1_wx_r[WORLD_W-2:0]) * PX_W'(cfg.inv_scale_x);
      f2_pz_r     <= PX_W'(f1_wz_r[WORLD_W-2:0]) * PX_W'(cfg.inv_scale_z);
      f2_lp_r     <= LP_W'(f1_smp_r) * LP_W'(cfg.height_scale);
    end
  end

  assign gx  = f2_px_r[PX_W-1:FRAC_BITS];
  assign gz  = f2_pz_r[PX_W-1:FRAC_BITS];
  assign x0f = gx[GX_W-1:FRAC_BITS];
  assign z0f = gz[GX_W-1:FRAC_BITS];
  // far corner must stay inside the grid
  assign x_off = (CMP_W'(x0f) + CMP_W'(1)) >= CMP_W'(dim);
  assign z_off = (CMP_W'(z0f) + CMP_W'(1)) >= CMP_W'(dim);
  assign lp_rnd = (LP_W + 1)'(f2_lp_r) + (LP_W + 1)'(1 << (LOAD_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (adv3) begin
      f3_mode_r  <= f2_mode_r;
      f3_idx_r   <= f2_idx_r;
      f3_off_r   <= f2_neg_r | x_off | z_off;
      f3_drop_r  <= (f2_mode_r == MODE_LOAD) && !f2_idx_ok_r;
      f3_x0_r    <= x0f[DIM_W-1:0];
      f3_z0_r    <= z0f[DIM_W-1:0];
      f3_tx_r    <= gx[FRAC_BITS-1:0];
      f3_tz_r    <= gz[FRAC_BITS-1:0];
      f3_wdata_r <= lp_rnd[LOAD_SHIFT+STORE_W-1:LOAD_SHIFT];
    end
  end

  assign row = ROW_W'(f3_z0_r) * ROW_W'(dim);

  always_comb begin
    ent.isq   = (f3_mode_r == MODE_QUERY);
    ent.off   = f3_off_r;
    ent.base  = ent.isq ? IDX_W'(row + ROW_W'(f3_x0_r)) : IDX_W'(f3_idx_r);
    ent.tx    = f3_tx_r;
    ent.tz    = f3_tz_r;
    ent.wdata = f3_wdata_r;
  end

  // out-of-range loads are dropped here
  assign q_push = f3_v_r && !f3_drop_r && !q_full;
  assign q_data = ENTRY_W'(ent);

endmodule
`default_nettype wire

[hdl/hbs_back.sv]
// Back part: writes loads, reads four corners from replicated stores, blends.
`default_nettype none
module hbs_back import hbs_pkg::*; #(
  parameter int MAX_DIM = 257,
  parameter int FRAC_BITS = 16,
  localparam int IDX_W = $clog2(MAX_DIM * MAX_DIM),
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int ENTRY_W = 2 + IDX_W + 2 * FRAC_BITS + STORE_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [DIM_W-1:0]   dim,
  input  wire logic [ENTRY_W-1:0] q_head,
  input  wire logic               q_empty,
  output logic                    q_pop,
  hbs_out_if.source               out_chan
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int W1    = FRAC_BITS + 1;
  localparam int P_W   = STORE_W + W1;
  localparam int S_W   = P_W + 1;

  typedef struct packed {
    logic                 isq;
    logic                 off;
    logic [IDX_W-1:0]     base;
    logic [FRAC_BITS-1:0] tx;
    logic [FRAC_BITS-1:0] tz;
    logic [STORE_W-1:0]   wdata;
  } qent_t;

  qent_t            ent;
  logic             adv, we;
  logic [IDX_W-1:0] addr [4];
  logic [STORE_W-1:0] rd [4];

  logic                 b1_v_r, b1_off_r;
  logic [FRAC_BITS-1:0] b1_tx_r, b1_tz_r;
  logic                 b2_v_r, b2_off_r;
  logic [FRAC_BITS-1:0] b2_tz_r;
  logic [P_W-1:0]       b2_p_r [4];
  logic                 b3_v_r, b3_off_r;
  logic [FRAC_BITS-1:0] b3_tz_r;
  logic [STORE_W-1:0]   b3_top_r, b3_bot_r;
  logic                 b4_v_r, b4_off_r;
  logic [P_W-1:0]       b4_q0_r, b4_q1_r;
  logic                 out_v_r, out_off_r;
  logic [HEIGHT_W-1:0]  out_h_r;

  logic [W1-1:0]  omtx, omtz;
  logic [S_W-1:0] s_top, s_bot, s_h;
  logic [S_W-1:0] half;

  assign ent   = qent_t'(q_head);
  assign adv   = !out_v_r || out_chan.ready;
  assign q_pop = adv && !q_empty;
  assign we    = q_pop && !ent.isq;
  assign half  = S_W'(1) << (FRAC_BITS - 1);

  assign addr[0] = ent.base;
  assign addr[1] = ent.base + IDX_W'(1);
  assign addr[2] = ent.base + IDX_W'(dim);
  assign addr[3] = ent.base + IDX_W'(dim) + IDX_W'(1);

  // one copy per corner, all written together by loads
  for (genvar k = 0; k < 4; k++) begin : g_store
    hbs_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (ent.base),
      .wdata (ent.wdata),
      .re    (adv),
      .raddr (addr[k]),
      .rdata (rd[k])
    );
  end

  assign omtx = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, b1_tx_r};
  assign omtz = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, b3_tz_r};

  assign s_top = S_W'(b2_p_r[0]) + S_W'(b2_p_r[1]) + half;
  assign s_bot = S_W'(b2_p_r[2]) + S_W'(b2_p_r[3]) + half;
  assign s_h   = S_W'(b4_q0_r) + S_W'(b4_q1_r) + half;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      b4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r  <= q_pop && ent.isq;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      b4_v_r  <= b3_v_r;
      out_v_r <= b4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_off_r  <= ent.off;
      b1_tx_r   <= ent.tx;
      b1_tz_r   <= ent.tz;

      b2_off_r  <= b1_off_r;
      b2_tz_r   <= b1_tz_r;
      b2_p_r[0] <= P_W'(rd[0]) * P_W'(omtx);
      b2_p_r[1] <= P_W'(rd[1]) * P_W'(b1_tx_r);
      b2_p_r[2] <= P_W'(rd[2]) * P_W'(omtx);
      b2_p_r[3] <= P_W'(rd[3]) * P_W'(b1_tx_r);

      b3_off_r  <= b2_off_r;
      b3_tz_r   <= b2_tz_r;
      b3_top_r  <= s_top[FRAC_BITS+STORE_W-1:FRAC_BITS];
      b3_bot_r  <= s_bot[FRAC_BITS+STORE_W-1:FRAC_BITS];

      b4_off_r  <= b3_off_r;
      b4_q0_r   <= P_W'(b3_top_r) * P_W'(omtz);
      b4_q1_r   <= P_W'(b3_bot_r) * P_W'(b3_tz_r);

      out_off_r <= b4_off_r;
      out_h_r   <= b4_off_r ? HEIGHT_W'(-(64'sd1 <<< FRAC_BITS))
                            : HEIGHT_W'(s_h[FRAC_BITS+STORE_W-1:FRAC_BITS]);
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.height      = out_h_r;
  assign out_chan.off_terrain = out_off_r;

endmodule
`default_nettype wire
